// File: src/mpbp_pkg.sv
// Shared types, constants and the character code table of the Morse pattern buffer player.
// Used by mpbp_encoder, morse_pattern_buffer_player_top and the testbench; no dependencies.
package mpbp_pkg;

	localparam int BUFFER_BYTES = 32;
	localparam int STORE_BITS   = BUFFER_BYTES * 8;
	localparam int ADDR_W       = $clog2(STORE_BITS);
	localparam int LEN_W        = $clog2(STORE_BITS + 1);
	localparam int CODE_W       = 6;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_CHAR    = 3'd1,
		CMD_RAW     = 3'd2,
		CMD_CLEAR   = 3'd3,
		CMD_RESTART = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_RD,
		ST_RESP
	} state_t;

	// one LED bit from the encoder
	typedef struct packed {
		logic vld;
		logic bit_val;
		logic last;
	} emit_t;

	// code is left aligned: first symbol at the MSB, 1 is a dash
	typedef struct packed {
		logic              known;
		logic              space;
		logic [2:0]        nsym;
		logic [CODE_W-1:0] code;
	} glyph_t;

	function automatic glyph_t glyph_lookup(input logic [7:0] c);
		logic [7:0] cu;
		glyph_t     g;
		cu = c;
		// fold lower case to upper case
		if (c >= "a" && c <= "z") begin
			cu = c - 8'd32;
		end
		g = '{known: 1'b1, space: 1'b0, nsym: 3'd0, code: 6'b000000};
		case (cu)
			" ":   g.space = 1'b1;
			"A":   begin g.nsym = 3'd2; g.code = 6'b010000; end
			"B":   begin g.nsym = 3'd4; g.code = 6'b100000; end
			"C":   begin g.nsym = 3'd4; g.code = 6'b101000; end
			"D":   begin g.nsym = 3'd3; g.code = 6'b100000; end
			"E":   begin g.nsym = 3'd1; g.code = 6'b000000; end
			"F":   begin g.nsym = 3'd4; g.code = 6'b001000; end
			"G":   begin g.nsym = 3'd3; g.code = 6'b110000; end
			"H":   begin g.nsym = 3'd4; g.code = 6'b000000; end
			"I":   begin g.nsym = 3'd2; g.code = 6'b000000; end
			"J":   begin g.nsym = 3'd4; g.code = 6'b011100; end
			"K":   begin g.nsym = 3'd3; g.code = 6'b101000; end
			"L":   begin g.nsym = 3'd4; g.code = 6'b010000; end
			"M":   begin g.nsym = 3'd2; g.code = 6'b110000; end
			"N":   begin g.nsym = 3'd2; g.code = 6'b100000; end
			"O":   begin g.nsym = 3'd3; g.code = 6'b111000; end
			"P":   begin g.nsym = 3'd4; g.code = 6'b011000; end
			"Q":   begin g.nsym = 3'd4; g.code = 6'b110100; end
			"R":   begin g.nsym = 3'd3; g.code = 6'b010000; end
			"S":   begin g.nsym = 3'd3; g.code = 6'b000000; end
			"T":   begin g.nsym = 3'd1; g.code = 6'b100000; end
			"U":   begin g.nsym = 3'd3; g.code = 6'b001000; end
			"V":   begin g.nsym = 3'd4; g.code = 6'b000100; end
			"W":   begin g.nsym = 3'd3; g.code = 6'b011000; end
			"X":   begin g.nsym = 3'd4; g.code = 6'b100100; end
			"Y":   begin g.nsym = 3'd4; g.code = 6'b101100; end
			"Z":   begin g.nsym = 3'd4; g.code = 6'b110000; end
			"0":   begin g.nsym = 3'd5; g.code = 6'b111110; end
			"1":   begin g.nsym = 3'd5; g.code = 6'b011110; end
			"2":   begin g.nsym = 3'd5; g.code = 6'b001110; end
			"3":   begin g.nsym = 3'd5; g.code = 6'b000110; end
			"4":   begin g.nsym = 3'd5; g.code = 6'b000010; end
			"5":   begin g.nsym = 3'd5; g.code = 6'b000000; end
			"6":   begin g.nsym = 3'd5; g.code = 6'b100000; end
			"7":   begin g.nsym = 3'd5; g.code = 6'b110000; end
			"8":   begin g.nsym = 3'd5; g.code = 6'b111000; end
			"9":   begin g.nsym = 3'd5; g.code = 6'b111100; end
			".":   begin g.nsym = 3'd6; g.code = 6'b010101; end
			",":   begin g.nsym = 3'd6; g.code = 6'b110011; end
			":":   begin g.nsym = 3'd6; g.code = 6'b111000; end
			"?":   begin g.nsym = 3'd6; g.code = 6'b001100; end
			8'h27: begin g.nsym = 3'd6; g.code = 6'b011110; end
			"-":   begin g.nsym = 3'd6; g.code = 6'b100001; end
			"/":   begin g.nsym = 3'd5; g.code = 6'b100100; end
			"(":   begin g.nsym = 3'd6; g.code = 6'b101101; end
			8'h22: begin g.nsym = 3'd6; g.code = 6'b010010; end
			"@":   begin g.nsym = 3'd6; g.code = 6'b011010; end
			"=":   begin g.nsym = 3'd5; g.code = 6'b100010; end
			default: g.known = 1'b0;
		endcase
		return g;
	endfunction

endpackage

// File: src/morse_pattern_buffer_player_top.sv
// Morse pattern buffer player: encodes characters into an LED bit store and plays it on ticks.
// Depends on mpbp_pkg and mpbp_encoder.
// A tick with bits left reads the store in ST_RD and a known character is encoded in ST_ENC;
// every word answers from ST_RESP. Words are taken one at a time, only in ST_IDLE.
// Reset clears length, play position and handshake state; repeat_q resets to 1.
module morse_pattern_buffer_player_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [7:0] char_code,
	input  logic       raw_bit,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       led,
	output logic       accepted
);
	import mpbp_pkg::*;

	state_t           state_q, state_d;
	emit_t            emit;
	glyph_t           glyph;
	logic             mem [STORE_BITS];
	logic             rd_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] pos_inc;
	logic             repeat_q;
	logic             res_led_q;
	logic             res_ok_q;
	logic             out_valid_q;
	logic             led_q;
	logic             accepted_q;
	logic             in_fire;
	logic             enc_start;
	logic             app_en;
	logic             app_bit;
	logic             can_app;
	logic             out_load;
	logic             can_play;

	assign glyph    = glyph_lookup(char_code);
	assign can_app  = (len_q < LEN_W'(STORE_BITS));
	assign can_play = (pos_q < len_q);
	assign pos_inc  = pos_q + 1'b1;

	mpbp_encoder u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (enc_start),
		.char_code (char_code),
		.emit      (emit)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_TICK && can_play) begin
						state_d = ST_RD;
					end else if (command == CMD_CHAR && glyph.known) begin
						state_d = ST_ENC;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_ENC: begin
				if (emit.vld && emit.last) begin
					state_d = ST_RESP;
				end
			end
			ST_RD:   state_d = ST_RESP;
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		in_fire   = in_valid && in_ready;
		enc_start = in_fire && (command == CMD_CHAR) && glyph.known;
		app_en    = (in_fire && (command == CMD_RAW)) || emit.vld;
		app_bit   = emit.vld ? emit.bit_val : raw_bit;
		out_load  = (state_q == ST_RESP) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// bit store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (app_en && can_app) begin
			mem[len_q[ADDR_W-1:0]] <= app_bit;
		end
		rd_q <= mem[pos_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pos_q    <= '0;
			repeat_q <= 1'b1;
		end else begin
			if (app_en && can_app) begin
				len_q <= len_q + 1'b1;
			end
			if (in_fire && command == CMD_CLEAR) begin
				len_q <= '0;
				pos_q <= '0;
			end
			if (in_fire && command == CMD_RESTART) begin
				pos_q <= '0;
			end
			if (state_q == ST_RD) begin
				// wrap at the end when looping
				pos_q <= (pos_inc >= len_q && repeat_q) ? '0 : pos_inc;
			end
			if (cfg_wr_en) begin
				repeat_q <= cfg_wr_data;
				if (cfg_wr_data && !can_play) begin
					pos_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_led_q <= 1'b0;
			res_ok_q  <= (command == CMD_RAW) && can_app;
		end
		if (state_q == ST_ENC && emit.vld && emit.last) begin
			res_ok_q <= can_app;
		end
		if (state_q == ST_RD) begin
			res_led_q <= rd_q;
			res_ok_q  <= 1'b1;
		end
		if (out_load) begin
			led_q      <= res_led_q;
			accepted_q <= res_ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign led       = led_q;
	assign accepted  = accepted_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(STORE_BITS))
		else $error("sequence length beyond store size");

	a_pos_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= len_q)
		else $error("play position past sequence length");

	a_emit_in_enc: assert property (@(posedge clk) disable iff (!arst_n)
		emit.vld |-> state_q == ST_ENC)
		else $error("encoder bit outside encode state");

	a_enc_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENC && emit.vld && emit.last) |=> state_q == ST_RESP)
		else $error("encode end did not reach response");

	a_rd_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> state_q == ST_RESP)
		else $error("store read did not reach response");

endmodule

// File: src/mpbp_encoder.sv
// Symbol sequencer: turns one character into its LED bit stream, one bit per cycle.
// Depends on mpbp_pkg (glyph table, emit_t).
module mpbp_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [7:0]      char_code,
	output mpbp_pkg::emit_t emit
);
	import mpbp_pkg::*;

	glyph_t            glyph;
	logic [CODE_W-1:0] code_q;
	logic [2:0]        nsym_q;
	logic [1:0]        step_q;
	logic [2:0]        gap_q;
	logic              busy_q;
	logic [1:0]        last_step;
	logic              in_sym;

	assign glyph     = glyph_lookup(char_code);
	assign in_sym    = (nsym_q != 3'd0);
	// a dot is 1,0 and a dash is 1,1,1,0
	assign last_step = code_q[CODE_W-1] ? 2'd3 : 2'd1;

	always_comb begin
		emit.vld     = busy_q;
		emit.bit_val = in_sym && (step_q != last_step);
		emit.last    = !in_sym && (gap_q == 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			nsym_q <= '0;
			step_q <= '0;
			gap_q  <= '0;
			code_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			nsym_q <= glyph.nsym;
			code_q <= glyph.code;
			step_q <= '0;
			gap_q  <= glyph.space ? 3'd4 : 3'd2;
		end else if (busy_q) begin
			if (in_sym) begin
				if (step_q == last_step) begin
					// advance to the next symbol
					step_q <= '0;
					code_q <= {code_q[CODE_W-2:0], 1'b0};
					nsym_q <= nsym_q - 3'd1;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end else begin
				gap_q <= gap_q - 3'd1;
				if (gap_q == 3'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: test/tb_morse_pattern_buffer_player_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for morse_pattern_buffer_player_top: directed and random command words,
// with the LED and accept flags predicted by an in-bench keyer and compared word by word.
// Depends on mpbp_pkg and the RTL of morse_pattern_buffer_player_top.
module tb_morse_pattern_buffer_player_top;
	import mpbp_pkg::*;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int RANDOM_WORDS  = 750;
	localparam int PHASES        = 8;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic [2:0] command;
		logic [7:0] char_code;
		logic       raw_bit;
	} key_word_t;

	typedef struct {
		logic [2:0] command;
		logic       led;
		logic       accepted;
	} key_result_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [2:0] command     = '0;
	logic [7:0] char_code   = '0;
	logic       raw_bit     = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic       led;
	logic       accepted;

	// keyer state as seen from outside
	logic [STORE_BITS-1:0] pattern_bits;
	logic [LEN_W-1:0]      pattern_len = '0;
	logic [LEN_W-1:0]      play_pos    = '0;
	logic                  loop_on     = 1'b1;

	string       char_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,:?'-/(\"@= ";
	key_word_t   words_pending[$];
	key_result_t results_due[$];
	bit          word_taken = 1'b0;
	int          burst_left = 0;
	int          gap_left   = 0;
	int          ready_left = 0;
	int          stall_left = 0;
	int          failures   = 0;
	int          results_checked = 0;
	int          words_by_cmd[8];
	int          dropped_bits = 0;
	int          wraps      = 0;
	int          end_ticks  = 0;
	int          cfg_writes = 0;

	morse_pattern_buffer_player_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.char_code  (char_code),
		.raw_bit    (raw_bit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.led        (led),
		.accepted   (accepted)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Symbols: '.' is on-off, '-' is on-on-on-off, ' ' is a single off bit, so a space
	// character ("  " plus the letter gap) comes out as four off bits. Empty means unknown.
	function automatic string morse_of(input logic [7:0] c);
		logic [7:0] cu;
		cu = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		case (cu)
			" ": return "  ";
			"A": return ".-";
			"B": return "-...";
			"C": return "-.-.";
			"D": return "-..";
			"E": return ".";
			"F": return "..-.";
			"G": return "--.";
			"H": return "....";
			"I": return "..";
			"J": return ".---";
			"K": return "-.-";
			"L": return ".-..";
			"M": return "--";
			"N": return "-.";
			"O": return "---";
			"P": return ".--.";
			"Q": return "--.-";
			"R": return ".-.";
			"S": return "...";
			"T": return "-";
			"U": return "..-";
			"V": return "...-";
			"W": return ".--";
			"X": return "-..-";
			"Y": return "-.--";
			"Z": return "--..";
			"0": return "-----";
			"1": return ".----";
			"2": return "..---";
			"3": return "...--";
			"4": return "....-";
			"5": return ".....";
			"6": return "-....";
			"7": return "--...";
			"8": return "---..";
			"9": return "----.";
			".": return ".-.-.-";
			",": return "--..--";
			":": return "---...";
			"?": return "..--..";
			8'h27: return ".----.";
			"-": return "-....-";
			"/": return "-..-.";
			"(": return "-.--.-";
			8'h22: return ".-..-.";
			"@": return ".--.-.";
			"=": return "-...-";
			default: return "";
		endcase
	endfunction

	// drop the bit once the store is full
	function automatic logic store_bit(input logic b);
		if (pattern_len >= STORE_BITS) begin
			dropped_bits++;
			return 1'b0;
		end
		pattern_bits[pattern_len] = b;
		pattern_len++;
		return 1'b1;
	endfunction

	function automatic logic store_char(input logic [7:0] c);
		string pat;
		pat = morse_of(c);
		if (pat.len() == 0) begin
			return 1'b0;
		end
		for (int i = 0; i < pat.len(); i++) begin
			if (pat[i] == " ") begin
				void'(store_bit(1'b0));
			end else begin
				void'(store_bit(1'b1));
				if (pat[i] == "-") begin
					void'(store_bit(1'b1));
					void'(store_bit(1'b1));
				end
				void'(store_bit(1'b0));
			end
		end
		// the answer reflects the last bit of the letter gap
		void'(store_bit(1'b0));
		return store_bit(1'b0);
	endfunction

	function automatic key_result_t keyer_step(input key_word_t w);
		key_result_t r;
		r.command  = w.command;
		r.led      = 1'b0;
		r.accepted = 1'b0;
		case (w.command)
			CMD_TICK: begin
				if (play_pos < pattern_len) begin
					r.led      = pattern_bits[play_pos];
					r.accepted = 1'b1;
					play_pos++;
					if (play_pos >= pattern_len && loop_on) begin
						play_pos = '0;
						wraps++;
					end
				end else begin
					end_ticks++;
				end
			end
			CMD_CHAR: r.accepted = store_char(w.char_code);
			CMD_RAW: r.accepted = store_bit(w.raw_bit);
			CMD_CLEAR: begin
				pattern_len = '0;
				play_pos    = '0;
			end
			CMD_RESTART: play_pos = '0;
			default: ;
		endcase
		return r;
	endfunction

	function automatic key_word_t random_word(input int clear_pct, input int tick_pct);
		key_word_t w;
		int r;
		r           = $urandom_range(0, 99);
		w.char_code = 8'($urandom_range(0, 255));
		w.raw_bit   = 1'($urandom_range(0, 1));
		if (r < clear_pct) begin
			w.command = CMD_CLEAR;
		end else if (r < clear_pct + tick_pct) begin
			w.command = CMD_TICK;
		end else if (r < clear_pct + tick_pct + 3) begin
			w.command = CMD_RESTART;
		end else if (r < clear_pct + tick_pct + 5) begin
			w.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		end else if (r < clear_pct + tick_pct + 15) begin
			w.command = CMD_RAW;
		end else begin
			w.command = CMD_CHAR;
			// mostly real characters, now and then any byte
			if ($urandom_range(0, 6) != 0) begin
				w.char_code = char_set[$urandom_range(0, char_set.len() - 1)];
			end
		end
		return w;
	endfunction

	task automatic queue_word(input logic [2:0] cmd, input logic [7:0] ch, input logic rb);
		key_word_t w;
		w.command   = cmd;
		w.char_code = ch;
		w.raw_bit   = rb;
		words_pending.push_back(w);
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (words_pending.size() != 0 || in_valid || results_due.size() != 0);
	endtask

	task automatic write_repeat(input logic v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		loop_on = v;
		// enabling repeat rewinds a finished position
		if (v && play_pos >= pattern_len) begin
			play_pos = '0;
		end
		cfg_writes++;
	endtask

	// sender: bursts of words with random gaps
	always @(negedge clk) begin
		key_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (words_pending.size() > 0) begin
				w = words_pending.pop_front();
				in_valid  <= 1'b1;
				command   <= w.command;
				char_code <= w.char_code;
				raw_bit   <= w.raw_bit;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: ready runs broken by stall runs
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (ready_left > 0) begin
			ready_left--;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			ready_left = $urandom_range(0, 30);
			stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
	end

	always @(posedge clk) begin
		key_word_t   taken;
		key_result_t want;
		if (arst_n && in_valid && in_ready) begin
			taken.command   = command;
			taken.char_code = char_code;
			taken.raw_bit   = raw_bit;
			results_due.push_back(keyer_step(taken));
			words_by_cmd[command]++;
			word_taken = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected output word led=%0b accepted=%0b", $time, led, accepted);
				failures++;
			end else begin
				want = results_due.pop_front();
				if (led !== want.led) begin
					$display("%0t: command %0d led expected %0b, got %0b",
						$time, want.command, want.led, led);
					failures++;
				end
				if (accepted !== want.accepted) begin
					$display("%0t: command %0d accepted expected %0b, got %0b",
						$time, want.command, want.accepted, accepted);
					failures++;
				end
			end
		end
	end

	initial begin
		key_word_t w;
		int n;
		int clear_pct;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty store, folding, space, odd glyphs, unknown bytes, raw bits, restart, spares, clear
		queue_word(CMD_TICK, 8'h00, 1'b0);
		queue_word(CMD_CHAR, "E", 1'b0);
		queue_word(CMD_TICK, 8'hFF, 1'b1);
		queue_word(CMD_CHAR, "a", 1'b0);
		queue_word(CMD_CHAR, " ", 1'b1);
		queue_word(CMD_CHAR, "?", 1'b0);
		queue_word(CMD_CHAR, 8'h00, 1'b1);
		queue_word(CMD_CHAR, 8'hFF, 1'b0);
		queue_word(CMD_CHAR, "z", 1'b0);
		queue_word(CMD_CHAR, 8'h22, 1'b0);
		queue_word(CMD_RAW, 8'h00, 1'b1);
		queue_word(CMD_RAW, 8'hFF, 1'b0);
		repeat (4) queue_word(CMD_TICK, 8'h00, 1'b0);
		queue_word(CMD_RESTART, 8'hFF, 1'b1);
		queue_word(CMD_TICK, 8'h00, 1'b0);
		queue_word(CMD_SPARE_FIRST, 8'hFF, 1'b1);
		queue_word(CMD_SPARE_MID, 8'h55, 1'b0);
		queue_word(CMD_SPARE_LAST, 8'hAA, 1'b1);
		queue_word(CMD_CLEAR, 8'h00, 1'b0);
		queue_word(CMD_TICK, 8'h00, 1'b0);
		queue_word(CMD_CHAR, "0", 1'b0);
		queue_word(CMD_CHAR, "T", 1'b0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_repeat((p < 4) ? p[0] : 1'($urandom_range(0, 1)));
			// some phases never clear, so the store fills and stays full
			clear_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 2 : 6;
			n = 0;
			while (n < RANDOM_WORDS / PHASES) begin
				w = random_word(clear_pct, loop_on ? 30 : 45);
				words_pending.push_back(w);
				n++;
			end
			wait_drained();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d output words: %0d ticks, %0d characters, %0d raw bits, %0d clears,",
			results_checked, words_by_cmd[CMD_TICK], words_by_cmd[CMD_CHAR],
			words_by_cmd[CMD_RAW], words_by_cmd[CMD_CLEAR]);
		$display("%0d restarts; %0d wraps, %0d ticks at end, %0d bits dropped full, %0d repeat writes.",
			words_by_cmd[CMD_RESTART], wraps, end_ticks, dropped_bits, cfg_writes);
		if (failures == 0) begin
			$display("** morse_pattern_buffer_player_top: PASSED **");
		end else begin
			$display("** morse_pattern_buffer_player_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d words pending and %0d results due",
			words_pending.size(), results_due.size());
		$display("** morse_pattern_buffer_player_top: FAILED **");
		$finish;
	end

endmodule
